>>> rtl/core/salk_pkg.sv
// ----------------------------------------------------------------------------
// salk_pkg
// Shared constants, codes and width helpers for the amplitude lookup core.
// ----------------------------------------------------------------------------
package salk_pkg;

	localparam int FIELD_W            = 32;
	localparam int SLOT_W             = 5;
	localparam int PIVOT_W            = 5;
	localparam int ROWCNT_W           = 6;
	localparam int PHASE_W            = 2;
	localparam int CFG_ADDR_W         = 1;
	localparam int DEFAULT_INDEX_BITS = 32;
	localparam int DEFAULT_MAX_ROWS   = 32;

	typedef enum logic {
		CMD_LOAD  = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_t;

	typedef enum logic [CFG_ADDR_W-1:0] {
		CFG_ANCHOR    = 1'b0,
		CFG_ROW_COUNT = 1'b1
	} cfg_reg_t;

	// masks, anchor and index are all cut to the narrower of the two widths
	function automatic int mask_width(input int index_bits);
		return (index_bits < FIELD_W) ? index_bits : FIELD_W;
	endfunction

	function automatic int addr_width(input int max_rows);
		return (max_rows > 1) ? $clog2(max_rows) : 1;
	endfunction

	function automatic int count_width(input int max_rows);
		return $clog2(max_rows + 1);
	endfunction

	function automatic int entry_width(input int index_bits, input int max_rows);
		return 1 + addr_width(max_rows) + 2 * mask_width(index_bits) + PHASE_W + PIVOT_W;
	endfunction

endpackage

>>> rtl/core/salk_front.sv
// ----------------------------------------------------------------------------
// salk_front
// Accepts input transactions, drops loads to absent rows, folds the row sign
// and the X/Z overlap into a phase increment, and forms the query residual.
// ----------------------------------------------------------------------------
module salk_front
	import salk_pkg::*;
#(
	parameter int INDEX_BITS = DEFAULT_INDEX_BITS,
	parameter int MAX_ROWS   = DEFAULT_MAX_ROWS
) (
	input  logic                                          in_valid,
	output logic                                          in_stall,
	input  logic                                          cmd,
	input  logic [SLOT_W-1:0]                             row_slot,
	input  logic [FIELD_W-1:0]                            x_bits,
	input  logic [FIELD_W-1:0]                            z_bits,
	input  logic                                          sign_bit,
	input  logic [PIVOT_W-1:0]                            pivot_col,
	input  logic [FIELD_W-1:0]                            query_index,
	input  logic [mask_width(INDEX_BITS)-1:0]             anchor,
	input  logic                                          q_full,
	output logic                                          q_push,
	output logic [entry_width(INDEX_BITS, MAX_ROWS)-1:0]  q_entry
);

	localparam int MW = mask_width(INDEX_BITS);
	localparam int SW = addr_width(MAX_ROWS);

	logic               slot_ok;
	logic               keep;
	logic [MW-1:0]      x_trim;
	logic [MW-1:0]      z_trim;
	logic [MW-1:0]      xz;
	logic [MW-1:0]      x_field;
	logic [PHASE_W-1:0] overlap;
	logic [PHASE_W-1:0] phase_add;

	assign in_stall = q_full;
	assign slot_ok  = int'(row_slot) < MAX_ROWS;
	assign keep     = (cmd == CMD_QUERY) || slot_ok;
	assign q_push   = in_valid && !in_stall && keep;

	assign x_trim = MW'(x_bits);
	assign z_trim = MW'(z_bits);
	assign xz     = x_trim & z_trim;

	// popcount of the overlap, only its value mod 4 matters
	always_comb begin
		overlap = '0;
		for (int i = 0; i < MW; i++) begin
			overlap = overlap + PHASE_W'(xz[i]);
		end
	end

	assign phase_add = {sign_bit, 1'b0} + overlap;

	// a query carries its starting residual in the X field
	assign x_field = (cmd == CMD_QUERY) ? (MW'(query_index) ^ anchor) : x_trim;

	assign q_entry = {cmd, SW'(row_slot), x_field, z_trim, phase_add, pivot_col};

endmodule

>>> rtl/core/salk_fifo.sv
// ----------------------------------------------------------------------------
// salk_fifo
// Two-entry queue between the front and the walker.
// ----------------------------------------------------------------------------
module salk_fifo
	import salk_pkg::*;
#(
	parameter int WIDTH = FIELD_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	output logic             pop_valid,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0] slot_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign full      = count_q == 2'd2;
	assign pop_valid = count_q != 2'd0;
	assign pop_data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> rtl/core/salk_back.sv
// ----------------------------------------------------------------------------
// salk_back
// Holds the support table, writes loaded rows and walks the rows for a
// query, one row per cycle, then presents the result in an output register.
// ----------------------------------------------------------------------------
module salk_back
	import salk_pkg::*;
#(
	parameter int INDEX_BITS = DEFAULT_INDEX_BITS,
	parameter int MAX_ROWS   = DEFAULT_MAX_ROWS
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          q_valid,
	input  logic [entry_width(INDEX_BITS, MAX_ROWS)-1:0]  q_entry,
	output logic                                          q_pop,
	input  logic [mask_width(INDEX_BITS)-1:0]             anchor,
	input  logic [ROWCNT_W-1:0]                           row_count,
	output logic                                          out_valid,
	input  logic                                          out_stall,
	output logic                                          is_nonzero,
	output logic [PHASE_W-1:0]                            phase_power
);

	localparam int MW = mask_width(INDEX_BITS);
	localparam int SW = addr_width(MAX_ROWS);
	localparam int CW = count_width(MAX_ROWS);

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_DONE
	} state_t;

	logic               e_kind;
	logic [SW-1:0]      e_slot;
	logic [MW-1:0]      e_x;
	logic [MW-1:0]      e_z;
	logic [PHASE_W-1:0] e_phase;
	logic [PIVOT_W-1:0] e_pivot;

	logic [MW-1:0]      mem_x [MAX_ROWS];
	logic [MW-1:0]      mem_z [MAX_ROWS];
	logic [PHASE_W-1:0] mem_ph [MAX_ROWS];
	logic [PIVOT_W-1:0] mem_pv [MAX_ROWS];

	logic [MW-1:0]      rd_x_s1;
	logic [MW-1:0]      rd_z_s1;
	logic [PHASE_W-1:0] rd_ph_s1;
	logic [PIVOT_W-1:0] rd_pv_s1;
	logic               rvalid_s1;

	state_t             state_q;
	logic [CW-1:0]      issue_q;
	logic [MW-1:0]      residual_q;
	logic [MW-1:0]      current_q;
	logic [PHASE_W-1:0] phase_q;
	logic               out_valid_q;
	logic               is_nonzero_q;
	logic [PHASE_W-1:0] phase_power_q;

	logic [CW-1:0]      limit;
	logic               more;
	logic [MW-1:0]      res_shift;
	logic               hit;
	logic [PHASE_W-1:0] row_phase;

	assign {e_kind, e_slot, e_x, e_z, e_phase, e_pivot} = q_entry;

	assign q_pop = (state_q == S_IDLE) && q_valid;

	always_comb begin
		if (int'(row_count) > MAX_ROWS) begin
			limit = CW'(MAX_ROWS);
		end else begin
			limit = CW'(row_count);
		end
	end

	assign more = issue_q < limit;

	// a pivot beyond the index width reads as a clear bit
	assign res_shift = residual_q >> rd_pv_s1;
	assign hit       = (int'(rd_pv_s1) < MW) && res_shift[0];
	assign row_phase = rd_ph_s1 + {^(rd_z_s1 & current_q), 1'b0};

	always_ff @(posedge clk) begin
		if (q_pop && (e_kind == CMD_LOAD)) begin
			mem_x[e_slot]  <= e_x;
			mem_z[e_slot]  <= e_z;
			mem_ph[e_slot] <= e_phase;
			mem_pv[e_slot] <= e_pivot;
		end
	end

	always_ff @(posedge clk) begin
		rd_x_s1  <= mem_x[issue_q[SW-1:0]];
		rd_z_s1  <= mem_z[issue_q[SW-1:0]];
		rd_ph_s1 <= mem_ph[issue_q[SW-1:0]];
		rd_pv_s1 <= mem_pv[issue_q[SW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			issue_q       <= '0;
			rvalid_s1     <= 1'b0;
			residual_q    <= '0;
			current_q     <= '0;
			phase_q       <= '0;
			out_valid_q   <= 1'b0;
			is_nonzero_q  <= 1'b0;
			phase_power_q <= '0;
		end else begin
			// a finishing query refills the output register itself
			if (out_valid_q && !out_stall && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (q_valid && (e_kind == CMD_QUERY)) begin
						residual_q <= e_x;
						current_q  <= anchor;
						phase_q    <= '0;
						issue_q    <= '0;
						rvalid_s1  <= 1'b0;
						state_q    <= S_WALK;
					end
				end
				S_WALK: begin
					// issue the next row read while the previous row is applied
					rvalid_s1 <= more;
					if (more) begin
						issue_q <= issue_q + CW'(1);
					end
					if (rvalid_s1 && hit) begin
						phase_q    <= phase_q + row_phase;
						current_q  <= current_q ^ rd_x_s1;
						residual_q <= residual_q ^ rd_x_s1;
					end
					if (!rvalid_s1 && !more) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					// hold until the output register is free
					if (!out_valid_q || !out_stall) begin
						out_valid_q   <= 1'b1;
						is_nonzero_q  <= residual_q == '0;
						phase_power_q <= (residual_q == '0) ? phase_q : '0;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign is_nonzero  = is_nonzero_q;
	assign phase_power = phase_power_q;

endmodule

>>> rtl/core/stabilizer_amplitude_lookup_core.sv
// ----------------------------------------------------------------------------
// stabilizer_amplitude_lookup_core
// Support table of stabilizer rows with an amplitude query walker.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): cmd selects a row load or a query.
// A load writes one table row and gives no result; a load to a row at or
// above MAX_ROWS is dropped. A query gives one result on the output channel
// (out_valid / out_stall): is_nonzero and phase_power (i to that power).
// Configuration (cfg_we / cfg_addr / cfg_wdata) sets the anchor index and
// the number of rows in use; write it only while no transaction is in flight.
// A query walks the rows in use one per cycle out of the table memory,
// N = min(row_count, MAX_ROWS) rows in all, and the walker takes a new
// query only once it has handed the last result to the output register.
// A load is written into the table while the walker is idle and starts
// no walk.
// A two-entry queue sits between input and walker, so input is taken while
// a query walks. If the receiver stalls, the result holds in the output
// register and the walker waits after finishing the next query.
// Reset clears the configuration, the queue and the walker; table rows are
// undefined until loaded.
// ----------------------------------------------------------------------------
module stabilizer_amplitude_lookup_core
	import salk_pkg::*;
#(
	parameter int INDEX_BITS = DEFAULT_INDEX_BITS,
	parameter int MAX_ROWS   = DEFAULT_MAX_ROWS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [FIELD_W-1:0]    cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  cmd,
	input  logic [SLOT_W-1:0]     row_slot,
	input  logic [FIELD_W-1:0]    x_bits,
	input  logic [FIELD_W-1:0]    z_bits,
	input  logic                  sign_bit,
	input  logic [PIVOT_W-1:0]    pivot_col,
	input  logic [FIELD_W-1:0]    query_index,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  is_nonzero,
	output logic [PHASE_W-1:0]    phase_power
);

	localparam int MW = mask_width(INDEX_BITS);
	localparam int EW = entry_width(INDEX_BITS, MAX_ROWS);

	logic [MW-1:0]       anchor_q;
	logic [ROWCNT_W-1:0] row_count_q;

	logic                q_push;
	logic                q_full;
	logic                q_valid;
	logic                q_pop;
	logic [EW-1:0]       push_entry;
	logic [EW-1:0]       head_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anchor_q    <= '0;
			row_count_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_ANCHOR:    anchor_q    <= MW'(cfg_wdata);
				CFG_ROW_COUNT: row_count_q <= cfg_wdata[ROWCNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	salk_front #(
		.INDEX_BITS (INDEX_BITS),
		.MAX_ROWS   (MAX_ROWS)
	) u_front (
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.row_slot    (row_slot),
		.x_bits      (x_bits),
		.z_bits      (z_bits),
		.sign_bit    (sign_bit),
		.pivot_col   (pivot_col),
		.query_index (query_index),
		.anchor      (anchor_q),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_entry     (push_entry)
	);

	salk_fifo #(
		.WIDTH (EW)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_entry),
		.full      (q_full),
		.pop_valid (q_valid),
		.pop       (q_pop),
		.pop_data  (head_entry)
	);

	salk_back #(
		.INDEX_BITS (INDEX_BITS),
		.MAX_ROWS   (MAX_ROWS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_entry     (head_entry),
		.q_pop       (q_pop),
		.anchor      (anchor_q),
		.row_count   (row_count_q),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.is_nonzero  (is_nonzero),
		.phase_power (phase_power)
	);

endmodule
